// File: rtl/idll_pkg.sv
package idll_pkg;

  // request codes
  localparam logic [2:0] OP_ADD_HEAD  = 3'd0;
  localparam logic [2:0] OP_ADD_TAIL  = 3'd1;
  localparam logic [2:0] OP_ADD_AFTER = 3'd2;
  localparam logic [2:0] OP_RM_HEAD   = 3'd3;
  localparam logic [2:0] OP_RM_TAIL   = 3'd4;
  localparam logic [2:0] OP_UNLINK    = 3'd5;
  localparam logic [2:0] OP_READ_PREV = 3'd6;
  localparam logic [2:0] OP_READ_NEXT = 3'd7;

  // field widths
  localparam int OP_W   = 3;
  localparam int CID_W  = 8;
  localparam int RPT_W  = 9;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 40;

  // reported value meaning "no cell"
  localparam logic [RPT_W-1:0] RPT_NONE = 9'd256;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [CID_W-1:0] cid_t;
  typedef logic [RPT_W-1:0] rpt_t;

endpackage

// File: rtl/indexed_doubly_linked_list.sv
// Results: a request passes through S_RD, S_W1, S_W2 and S_DONE, and its result is
// registered when S_DONE finds the output free. A new request is taken only in S_IDLE;
// the sequencer reads the two link memories once and writes each of them in S_W1 and S_W2
// (one write port each). Reset: synchronous, active low; afterwards a link init sweep over
// all CELLS cells rebuilds the full list 0..CELLS-1, with in_tready low until it finishes.
module indexed_doubly_linked_list import idll_pkg::*; #(
  parameter int CELLS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [2:0] req_type, [10:3] cell_req, [18:11] anchor_cell, [23:19] zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] status, [9:1] out_cell, [18:10] head_cell, [27:19] tail_cell,
  // [36:28] cell_count, [39:37] zero
  output logic [OUT_W-1:0] out_tdata
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW = $clog2(CELLS + 1);
  localparam logic [LW-1:0] NIL      = LW'(CELLS);
  localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_W1   = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  function automatic rpt_t report(input logic [LW-1:0] v);
    report = (v < NIL) ? RPT_W'(v) : RPT_NONE;
  endfunction

  logic [2:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  op_t            op_r;
  cid_t           cell_r, anchor_r;
  logic           fail_r, empty_r;
  logic [LW-1:0]  head_r, head_nxt;
  logic [LW-1:0]  tail_r, tail_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [LW-1:0]  res_r, res_nxt;
  logic           stat_r, stat_nxt;
  logic [LW-1:0]  rn_r, rp_r;
  logic [LW-1:0]  rd_n_r, rd_p_r;
  logic           out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  // link memories
  logic [LW-1:0] next_mem [CELLS];
  logic [LW-1:0] prev_mem [CELLS];
  logic          nw_en, pw_en;
  logic [AW-1:0] nw_addr, pw_addr, n_raddr, p_raddr;
  logic [LW-1:0] nw_data, pw_data;

  logic          c_ok, a_ok, head_ok, tail_ok, rn_ok, rp_ok, rn_q_ok, rp_q_ok;
  logic          fail_c;
  logic [LW-1:0] c_link, a_link, len_up, len_dn;
  logic [AW-1:0] c_addr, a_addr;
  logic          accept, out_free;

  assign c_ok    = 32'(cell_r) < CELLS;
  assign a_ok    = 32'(anchor_r) < CELLS;
  assign head_ok = head_r < NIL;
  assign tail_ok = tail_r < NIL;
  assign rn_ok   = rd_n_r < NIL;
  assign rp_ok   = rd_p_r < NIL;
  assign rn_q_ok = rn_r < NIL;
  assign rp_q_ok = rp_r < NIL;
  assign c_link  = LW'(cell_r);
  assign a_link  = LW'(anchor_r);
  assign c_addr  = AW'(cell_r);
  assign a_addr  = AW'(anchor_r);
  assign len_up  = (len_r < NIL) ? len_r + LW'(1) : len_r;
  assign len_dn  = (len_r != '0) ? len_r - LW'(1) : len_r;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // request rejection, judged on the list before the step
  always_comb begin
    case (op_r)
      OP_ADD_HEAD, OP_ADD_TAIL:   fail_c = !c_ok;
      OP_ADD_AFTER:               fail_c = !c_ok || !a_ok || !head_ok;
      OP_RM_HEAD, OP_RM_TAIL:     fail_c = !head_ok;
      OP_UNLINK:                  fail_c = !c_ok || !head_ok;
      default:                    fail_c = !c_ok;
    endcase
  end

  // read addresses, held through the read cycle
  assign n_raddr = (op_r == OP_ADD_AFTER) ? a_addr :
                   (op_r == OP_RM_HEAD)   ? AW'(head_r) : c_addr;
  assign p_raddr = (op_r == OP_RM_TAIL)   ? AW'(tail_r) : c_addr;

  // link write selection
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = c_addr;
    nw_data = NIL;
    pw_en   = 1'b0;
    pw_addr = c_addr;
    pw_data = NIL;
    if (state_r == S_CLR) begin
      nw_en   = 1'b1;
      nw_addr = clr_r;
      nw_data = LW'(clr_r) + LW'(1);
      pw_en   = 1'b1;
      pw_addr = clr_r;
      pw_data = (clr_r == '0) ? NIL : LW'(clr_r) - LW'(1);
    end else if (state_r == S_W1 && !fail_r) begin
      case (op_r)
        OP_ADD_HEAD, OP_ADD_TAIL: begin
          pw_en   = 1'b1;
          pw_data = (empty_r || op_r == OP_ADD_HEAD) ? NIL : tail_r;
          nw_en   = 1'b1;
          nw_data = (empty_r || op_r == OP_ADD_TAIL) ? NIL : head_r;
        end
        OP_ADD_AFTER: begin
          nw_en   = 1'b1;
          nw_addr = a_addr;
          nw_data = c_link;
          pw_en   = rn_ok;
          pw_addr = AW'(rd_n_r);
          pw_data = c_link;
        end
        OP_RM_HEAD: begin
          pw_en   = rn_ok;
          pw_addr = AW'(rd_n_r);
          nw_en   = 1'b1;
          nw_addr = AW'(head_r);
        end
        OP_RM_TAIL: begin
          nw_en   = rp_ok;
          nw_addr = AW'(rd_p_r);
          pw_en   = 1'b1;
          pw_addr = AW'(tail_r);
        end
        OP_UNLINK: begin
          nw_en   = rp_ok;
          nw_addr = AW'(rd_p_r);
          nw_data = rd_n_r;
          pw_en   = rn_ok;
          pw_addr = AW'(rd_n_r);
          pw_data = rd_p_r;
        end
        default: begin
          nw_en = 1'b0;
          pw_en = 1'b0;
        end
      endcase
    end else if (state_r == S_W2 && !fail_r) begin
      case (op_r)
        OP_ADD_HEAD: begin
          pw_en   = !empty_r;
          pw_addr = AW'(head_r);
          pw_data = c_link;
        end
        OP_ADD_TAIL: begin
          nw_en   = !empty_r && tail_ok;
          nw_addr = AW'(tail_r);
          nw_data = c_link;
        end
        OP_ADD_AFTER: begin
          pw_en   = 1'b1;
          pw_data = a_link;
          nw_en   = 1'b1;
          nw_data = rn_q_ok ? rn_r : NIL;
        end
        OP_RM_HEAD: begin
          pw_en   = 1'b1;
          pw_addr = AW'(head_r);
        end
        OP_RM_TAIL: begin
          nw_en   = 1'b1;
          nw_addr = AW'(tail_r);
        end
        OP_UNLINK: begin
          pw_en = 1'b1;
          nw_en = 1'b1;
        end
        default: begin
          nw_en = 1'b0;
          pw_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    rd_n_r <= next_mem[n_raddr];
    rd_p_r <= prev_mem[p_raddr];
  end

  // head, tail, count and result at the end of the step
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    len_nxt  = len_r;
    res_nxt  = res_r;
    stat_nxt = stat_r;
    if (state_r == S_W2) begin
      stat_nxt = fail_r;
      res_nxt  = NIL;
      if (!fail_r) begin
        case (op_r)
          OP_ADD_HEAD, OP_ADD_TAIL: begin
            res_nxt = c_link;
            if (empty_r) begin
              head_nxt = c_link;
              tail_nxt = c_link;
              len_nxt  = LW'(1);
            end else begin
              if (op_r == OP_ADD_HEAD) begin
                head_nxt = c_link;
              end else begin
                tail_nxt = c_link;
              end
              len_nxt = len_up;
            end
          end
          OP_ADD_AFTER: begin
            res_nxt = c_link;
            if (!rn_q_ok) begin
              tail_nxt = c_link;
            end
            len_nxt = len_up;
          end
          OP_RM_HEAD: begin
            res_nxt  = head_r;
            head_nxt = rn_q_ok ? rn_r : NIL;
            if (!rn_q_ok) begin
              tail_nxt = NIL;
            end
            len_nxt = len_dn;
          end
          OP_RM_TAIL: begin
            res_nxt  = tail_r;
            tail_nxt = rp_q_ok ? rp_r : NIL;
            if (!rp_q_ok) begin
              head_nxt = NIL;
            end
            len_nxt = len_dn;
          end
          OP_UNLINK: begin
            res_nxt = c_link;
            if (!rp_q_ok) begin
              head_nxt = rn_r;
            end
            if (!rn_q_ok) begin
              tail_nxt = rp_r;
            end
            len_nxt = len_dn;
          end
          OP_READ_PREV: res_nxt = rp_r;
          default:      res_nxt = rn_r;
        endcase
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_W1;
      S_W1:   state_nxt = S_W2;
      S_W2:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      head_r       <= '0;
      tail_r       <= LW'(CELLS - 1);
      len_r        <= LW'(CELLS);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      len_r   <= len_nxt;
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tdata[2:0];
      cell_r   <= in_tdata[10:3];
      anchor_r <= in_tdata[18:11];
    end
    if (state_r == S_RD) begin
      fail_r  <= fail_c;
      empty_r <= !head_ok;
    end
    if (state_r == S_W1) begin
      rn_r <= rd_n_r;
      rp_r <= rd_p_r;
    end
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    if (state_r == S_DONE && out_free) begin
      out_tdata_r <= {3'b000, RPT_W'(len_r), report(tail_r), report(head_r),
                      report(res_r), stat_r};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import idll_pkg::*;

  localparam int POOL        = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SHOW_LIMIT  = 10;

  // result fields, lowest bits last so the struct lines up with out_tdata[36:0]
  typedef struct packed {
    rpt_t count;
    rpt_t tail;
    rpt_t head;
    rpt_t cell_id;
    logic status;
  } reply_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  indexed_doubly_linked_list #(.CELLS(POOL)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the link memories and list registers
  rpt_t next_of [POOL];
  rpt_t prev_of [POOL];
  rpt_t head_now;
  rpt_t tail_now;
  rpt_t count_now;

  reply_t expected_replies [$];

  // walk of the list, used only to pick stimulus
  cid_t member_q [$];
  bit   on_list [POOL];

  int cycle_count   = 0;
  int mismatches    = 0;
  int replies_seen  = 0;
  int refused_count = 0;
  int emptied_count = 0;
  int filled_count  = 0;
  int op_hits [8];
  int burst_left    = 0;
  bit steady        = 1'b0;

  function automatic void reset_list_mirror();
    for (int i = 0; i < POOL; i++) begin
      next_of[i] = (i == POOL - 1) ? RPT_NONE : rpt_t'(i + 1);
      prev_of[i] = (i == 0) ? RPT_NONE : rpt_t'(i - 1);
    end
    head_now  = '0;
    tail_now  = rpt_t'(POOL - 1);
    count_now = rpt_t'(POOL);
  endfunction

  function automatic void count_up();
    if (count_now < rpt_t'(POOL)) begin
      count_now++;
      if (count_now == rpt_t'(POOL)) filled_count++;
    end
  endfunction

  function automatic void count_down();
    if (count_now > 0) begin
      count_now--;
      if (count_now == 0) emptied_count++;
    end
  endfunction

  // apply one accepted request to the mirror and queue the reply it must give
  function automatic void predict_list_op(op_t op, cid_t c, cid_t a);
    reply_t r;
    rpt_t   h;
    rpt_t   p;
    rpt_t   n;
    r.status  = 1'b0;
    r.cell_id = RPT_NONE;
    case (op)
      OP_ADD_HEAD, OP_ADD_TAIL: begin
        if (head_now == RPT_NONE) begin
          prev_of[c] = RPT_NONE;
          next_of[c] = RPT_NONE;
          head_now   = {1'b0, c};
          tail_now   = {1'b0, c};
          if (count_now != 1 && count_now == rpt_t'(POOL) - 1) filled_count += 0;
          count_now  = 9'd1;
        end else if (op == OP_ADD_HEAD) begin
          h = head_now;
          prev_of[c]      = RPT_NONE;
          next_of[c]      = h;
          prev_of[h[7:0]] = {1'b0, c};
          head_now        = {1'b0, c};
          count_up();
        end else begin
          h = tail_now;
          prev_of[c] = h;
          next_of[c] = RPT_NONE;
          if (h != RPT_NONE) next_of[h[7:0]] = {1'b0, c};
          tail_now = {1'b0, c};
          count_up();
        end
        r.cell_id = {1'b0, c};
      end
      OP_ADD_AFTER: begin
        if (head_now == RPT_NONE) begin
          r.status = 1'b1;
        end else begin
          n = next_of[a];
          next_of[a] = {1'b0, c};
          if (n != RPT_NONE) prev_of[n[7:0]] = {1'b0, c};
          else tail_now = {1'b0, c};
          prev_of[c] = {1'b0, a};
          next_of[c] = n;
          count_up();
          r.cell_id = {1'b0, c};
        end
      end
      OP_RM_HEAD: begin
        h = head_now;
        if (h == RPT_NONE) begin
          r.status = 1'b1;
        end else begin
          n = next_of[h[7:0]];
          head_now = n;
          if (n == RPT_NONE) tail_now = RPT_NONE;
          else prev_of[n[7:0]] = RPT_NONE;
          count_down();
          prev_of[h[7:0]] = RPT_NONE;
          next_of[h[7:0]] = RPT_NONE;
          r.cell_id = h;
        end
      end
      OP_RM_TAIL: begin
        h = tail_now;
        if (h == RPT_NONE) begin
          r.status = 1'b1;
        end else begin
          p = prev_of[h[7:0]];
          tail_now = p;
          if (p == RPT_NONE) head_now = RPT_NONE;
          else next_of[p[7:0]] = RPT_NONE;
          count_down();
          prev_of[h[7:0]] = RPT_NONE;
          next_of[h[7:0]] = RPT_NONE;
          r.cell_id = h;
        end
      end
      OP_UNLINK: begin
        if (head_now == RPT_NONE) begin
          r.status = 1'b1;
        end else begin
          p = prev_of[c];
          n = next_of[c];
          if (p != RPT_NONE) next_of[p[7:0]] = n;
          else head_now = n;
          if (n != RPT_NONE) prev_of[n[7:0]] = p;
          else tail_now = p;
          count_down();
          prev_of[c] = RPT_NONE;
          next_of[c] = RPT_NONE;
          r.cell_id = {1'b0, c};
        end
      end
      OP_READ_PREV: r.cell_id = prev_of[c];
      default:      r.cell_id = next_of[c];
    endcase
    r.head  = head_now;
    r.tail  = tail_now;
    r.count = count_now;
    if (r.status) refused_count++;
    op_hits[op]++;
    expected_replies.push_back(r);
  endfunction

  // drive one request; the sender runs in bursts with random gaps between them
  task automatic send_request(op_t op, cid_t c, cid_t a);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 4));
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, a, c, op};
    do @(posedge clk); while (!in_tready);
    predict_list_op(op, c, a);
  endtask

  // stop sending until every reply has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void collect_members();
    rpt_t cur;
    int   steps;
    member_q.delete();
    foreach (on_list[i]) on_list[i] = 1'b0;
    cur   = head_now;
    steps = 0;
    while (cur != RPT_NONE && steps < POOL && !on_list[cur[7:0]]) begin
      on_list[cur[7:0]] = 1'b1;
      member_q.push_back(cur[7:0]);
      cur = next_of[cur[7:0]];
      steps++;
    end
  endfunction

  function automatic cid_t pick_free();
    cid_t c;
    do c = cid_t'($urandom_range(0, POOL - 1)); while (on_list[c]);
    return c;
  endfunction

  function automatic cid_t pick_member();
    return member_q[$urandom_range(0, member_q.size() - 1)];
  endfunction

  // links as laid down by the init sweep
  task automatic test_reset_chain();
    send_request(OP_READ_PREV, 8'd0,   8'd255);
    send_request(OP_READ_NEXT, 8'd255, 8'd0);
    send_request(OP_READ_NEXT, 8'd0,   8'd0);
    send_request(OP_READ_PREV, 8'd255, 8'd255);
    send_request(OP_READ_NEXT, 8'd127, 8'd0);
    send_request(OP_READ_PREV, 8'd128, 8'd0);
  endtask

  // updates at both ends and in the middle of the full list
  task automatic test_end_updates();
    send_request(OP_RM_HEAD,   8'd0,   8'd0);
    send_request(OP_RM_TAIL,   8'd255, 8'd255);
    send_request(OP_ADD_HEAD,  8'd255, 8'd0);
    send_request(OP_ADD_TAIL,  8'd0,   8'd255);
    send_request(OP_UNLINK,    8'd255, 8'd0);
    send_request(OP_UNLINK,    8'd0,   8'd0);
    send_request(OP_ADD_AFTER, 8'd0,   8'd254);
    send_request(OP_ADD_AFTER, 8'd255, 8'd1);
    send_request(OP_READ_NEXT, 8'd1,   8'd0);
    send_request(OP_READ_PREV, 8'd255, 8'd0);
    send_request(OP_UNLINK,    8'd100, 8'd0);
    send_request(OP_ADD_HEAD,  8'd100, 8'd255);
  endtask

  // drain to empty, refused requests on the empty list, single-cell cases
  task automatic test_empty_list();
    int   guard;
    op_t  op;
    guard = 0;
    while (head_now != RPT_NONE && guard < 2 * POOL) begin
      collect_members();
      case ($urandom_range(0, 2))
        0:       send_request(OP_RM_HEAD, cid_t'($urandom), cid_t'($urandom));
        1:       send_request(OP_RM_TAIL, cid_t'($urandom), cid_t'($urandom));
        default: send_request(OP_UNLINK, pick_member(), cid_t'($urandom));
      endcase
      guard++;
    end
    send_request(OP_RM_HEAD,   8'd0,   8'd0);
    send_request(OP_RM_TAIL,   8'd255, 8'd255);
    send_request(OP_ADD_AFTER, 8'd7,   8'd3);
    send_request(OP_UNLINK,    8'd7,   8'd0);
    send_request(OP_READ_PREV, 8'd7,   8'd0);
    send_request(OP_READ_NEXT, 8'd7,   8'd0);
    // only cell, via add at tail then add at head
    send_request(OP_ADD_TAIL,  8'd200, 8'd0);
    send_request(OP_RM_HEAD,   8'd0,   8'd0);
    send_request(OP_ADD_HEAD,  8'd9,   8'd0);
    send_request(OP_ADD_AFTER, 8'd10,  8'd9);
    send_request(OP_RM_TAIL,   8'd0,   8'd0);
    send_request(OP_UNLINK,    8'd9,   8'd0);
    op = OP_ADD_TAIL;
    send_request(op, 8'd33, 8'd0);
  endtask

  // mostly well-formed traffic around a drifting fill level, some raw noise
  task automatic test_random_traffic(int n_items);
    int   goal;
    int   r;
    op_t  op;
    cid_t c;
    cid_t a;
    goal = 128;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 5))
          0:       goal = 0;
          1:       goal = $urandom_range(1, 3);
          2:       goal = $urandom_range(4, 40);
          3:       goal = $urandom_range(100, 200);
          4:       goal = POOL;
          default: goal = $urandom_range(230, POOL - 1);
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      collect_members();
      c = cid_t'($urandom);
      a = cid_t'($urandom);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // broken sequences: any code with any cells
        op = op_t'($urandom_range(0, 7));
      end else if (r < 22) begin
        op = $urandom_range(0, 1) ? OP_READ_NEXT : OP_READ_PREV;
      end else if ((member_q.size() < goal ||
                    (member_q.size() == 0 && $urandom_range(0, 1)))
                   && member_q.size() < POOL) begin
        c = pick_free();
        case ($urandom_range(0, 2))
          0:       op = OP_ADD_HEAD;
          1:       op = OP_ADD_TAIL;
          default: begin
            op = OP_ADD_AFTER;
            if (member_q.size() != 0) a = pick_member();
          end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_RM_HEAD;
          1:       op = OP_RM_TAIL;
          default: begin
            op = OP_UNLINK;
            if (member_q.size() != 0) c = pick_member();
          end
        endcase
      end
      send_request(op, c, a);
    end
  endtask

  // receiver stall pattern, switching at random between four modes
  int ready_mode  = 0;
  int ready_phase = 0;
  always @(negedge clk) begin
    if (ready_phase % 50 == 0) ready_mode = $urandom_range(0, 3);
    ready_phase++;
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= (ready_phase % 5 < 3);
    endcase
  end

  // compare every reply transaction with the oldest expectation
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[36:0];
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected reply: status %0d cell %0d head %0d tail %0d count %0d",
                   got.status, got.cell_id, got.head, got.tail, got.count);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.cell_id !== want.cell_id ||
            got.head !== want.head || got.tail !== want.tail ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display({"reply %0d: exp st %0d cell %0d head %0d tail %0d cnt %0d,",
                      " got st %0d cell %0d head %0d tail %0d cnt %0d"},
                     replies_seen, want.status, want.cell_id, want.head, want.tail,
                     want.count, got.status, got.cell_id, got.head, got.tail,
                     got.count);
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[indexed_doubly_linked_list] ERROR");
      $finish;
    end
  end

  initial begin
    reset_list_mirror();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_chain();
    test_end_updates();
    test_empty_list();
    test_random_traffic(1000);
    hold_until_drained();
    test_random_traffic(1000);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display({"Checked %0d replies, %0d refused on an empty list;",
              " list emptied %0d times, filled %0d times."},
             replies_seen, refused_count, emptied_count, filled_count);
    $display({"Requests per code: add head %0d, add tail %0d, add after %0d,",
              " rm head %0d, rm tail %0d, unlink %0d, reads %0d/%0d."},
             op_hits[OP_ADD_HEAD], op_hits[OP_ADD_TAIL], op_hits[OP_ADD_AFTER],
             op_hits[OP_RM_HEAD], op_hits[OP_RM_TAIL], op_hits[OP_UNLINK],
             op_hits[OP_READ_PREV], op_hits[OP_READ_NEXT]);
    if (mismatches == 0) begin
      $display("[indexed_doubly_linked_list] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[indexed_doubly_linked_list] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/idll_pkg.sv
rtl/indexed_doubly_linked_list.sv
test/testbench.sv
